@@ rtl/ordered_list_table_engine_assert.svh @@
// Assertion macros for the ordered list table engine; empty under synthesis.
`ifndef ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every clock edge, suspended while reset is asserted.
`define OLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define OLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define OLT_ASSERT(lbl, prop, msg)
`define OLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/olt_pkg.sv @@
// Types and constants shared by the ordered list table engine.
`default_nettype none
package olt_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned PosW  = 7;
  localparam int unsigned StatW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_READ    = 3'd1,
    CMD_FIND    = 3'd2,
    CMD_REM_IDX = 3'd3,
    CMD_REM_VAL = 3'd4,
    CMD_INSERT  = 3'd5,
    CMD_SET     = 3'd6
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;      // what the entry register takes this cycle
    logic     cmp_en;  // capture the compare against the incoming value
    logic     rd_sel;  // drive the entry onto the read bus
  } cell_ctrl_t;

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic [StatW-1:0]        status;
    logic [PosW-1:0]         count;
  } out_t;

endpackage
`default_nettype wire

@@ rtl/olt_cell.sv @@
// One list cell: holds one entry, compares it, and shifts with its neighbors.
`default_nettype none
module olt_cell
  import olt_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic signed [DataW-1:0] cmp_value_i,
  input  wire logic signed [DataW-1:0] load_value_i,
  input  wire logic signed [DataW-1:0] left_i,
  input  wire logic signed [DataW-1:0] right_i,
  output logic signed [DataW-1:0]      entry_o,
  output logic                         match_o,
  output logic signed [DataW-1:0]      rd_data_o
);

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    match_q;

  always_comb begin
    unique case (ctrl_i.op)
      CELL_HOLD:  entry_d = entry_q;
      CELL_LOAD:  entry_d = load_value_i;
      CELL_LEFT:  entry_d = left_i;
      CELL_RIGHT: entry_d = right_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.cmp_en) begin
      match_q <= (entry_q == cmp_value_i);
    end
  end

  assign entry_o   = entry_q;
  assign match_o   = match_q;
  assign rd_data_o = ctrl_i.rd_sel ? entry_q : '0;

endmodule
`default_nettype wire

@@ rtl/ordered_list_table_engine.sv @@
// Ordered list table engine: a row of list cells, the command sequencer and the result register.
//
// On the accept edge each cell compares its entry with the incoming value and the command is
// captured; in the following cycle the whole row shifts up, shifts down, loads or holds in one
// step, the count is updated and the result beat is registered. A new beat is accepted in the
// cycle its predecessor's result leaves, and none is accepted while a command executes.
// The entries come out of reset unwritten and need no clearing pass; only the count and the
// handshake flags reset.
`default_nettype none
`include "ordered_list_table_engine_assert.svh"
module ordered_list_table_engine
  import olt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  logic                    busy_q;
  logic                    out_valid_q;
  out_t                    out_q, out_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CmdW-1:0]         cmd_q;
  logic signed [DataW-1:0] val_q;
  logic [PosW-1:0]         pos_q;

  logic                    in_fire;
  cell_ctrl_t              ctrl      [CAPACITY];
  cell_op_e                op        [CAPACITY];
  logic signed [DataW-1:0] entry     [CAPACITY];
  logic signed [DataW-1:0] left_val  [CAPACITY];
  logic signed [DataW-1:0] right_val [CAPACITY];
  logic signed [DataW-1:0] rd_data   [CAPACITY];
  logic [CAPACITY-1:0]     match;
  logic [CAPACITY-1:0]     hit;
  logic [CAPACITY-1:0]     past_hit;
  logic [CAPACITY-1:0]     at_pos;
  logic [CAPACITY-1:0]     above_pos;
  logic [CAPACITY-1:0]     at_cnt;
  logic [CAPACITY-1:0]     occupied;

  logic [CmpW-1:0]         pos_x, cnt_x;
  logic                    full, found;
  logic signed [DataW-1:0] rd_bus;
  logic [StatW-1:0]        status;
  logic signed [DataW-1:0] data;

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // The cell row; each cell sees its neighbors' entries every cycle.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_val[g] = val_q;
    end else begin : g_left
      assign left_val[g] = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val[g] = entry[g];
    end else begin : g_right
      assign right_val[g] = entry[g+1];
    end

    assign at_pos[g]    = (CmpW'(g) == pos_x);
    assign above_pos[g] = (CmpW'(g) > pos_x);
    assign at_cnt[g]    = (CmpW'(g) == cnt_x);
    assign occupied[g]  = (CmpW'(g) < cnt_x);
    assign hit[g]       = match[g] && occupied[g];
    // Set from the first matching entry upward: these cells close the gap.
    assign past_hit[g]  = |hit[g:0];

    assign ctrl[g] = '{op: op[g], cmp_en: in_fire, rd_sel: at_pos[g]};

    olt_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[g]),
      .cmp_value_i  (in_i.value),
      .load_value_i (val_q),
      .left_i       (left_val[g]),
      .right_i      (right_val[g]),
      .entry_o      (entry[g]),
      .match_o      (match[g]),
      .rd_data_o    (rd_data[g])
    );
  end

  assign pos_x = CmpW'(pos_q);
  assign cnt_x = CmpW'(cnt_q);
  assign full  = (cnt_q == CntW'(CAPACITY));
  assign found = |hit;

  // At most one cell drives a nonzero word, so an OR merges the read bus.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | rd_data[i];
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    status = ST_OK;
    data   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      op[i] = CELL_HOLD;
    end
    if (busy_q) begin
      unique case (cmd_e'(cmd_q))
        CMD_APPEND: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            cnt_d = cnt_q + CntW'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (at_cnt[i]) op[i] = CELL_LOAD;
            end
          end
        end
        CMD_READ: begin
          if (pos_x >= cnt_x) status = ST_RANGE;
          else                data   = rd_bus;
        end
        CMD_FIND: begin
          if (found) begin
            data = val_q;
          end else begin
            status = ST_MISS;
            data   = '1;
          end
        end
        CMD_REM_IDX: begin
          if (pos_x >= cnt_x) begin
            status = ST_RANGE;
          end else begin
            cnt_d = cnt_q - CntW'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (at_pos[i] || above_pos[i]) op[i] = CELL_RIGHT;
            end
          end
        end
        CMD_REM_VAL: begin
          if (!found) begin
            status = ST_MISS;
          end else begin
            cnt_d = cnt_q - CntW'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (past_hit[i]) op[i] = CELL_RIGHT;
            end
          end
        end
        CMD_INSERT: begin
          // The range check wins over the full check.
          if (pos_x > cnt_x) begin
            status = ST_RANGE;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            cnt_d = cnt_q + CntW'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (at_pos[i])         op[i] = CELL_LOAD;
              else if (above_pos[i]) op[i] = CELL_LEFT;
            end
          end
        end
        CMD_SET: begin
          if (pos_x >= cnt_x) begin
            status = ST_RANGE;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (at_pos[i]) op[i] = CELL_LOAD;
            end
          end
        end
        default: begin
        end
      endcase
    end
    out_d = '{data: data, status: status, count: PosW'(cnt_d)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      busy_q <= in_fire;
      cnt_q  <= cnt_d;
      if (busy_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_i.cmd;
      val_q <= in_i.value;
      pos_q <= in_i.position;
    end
    if (busy_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The count is unknown before the first reset edge, so only a released reset is checked.
  `OLT_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || (cnt_q <= CntW'(CAPACITY)), "entry count above capacity")
  `OLT_ASSERT(a_busy_blocks, busy_q |-> !in_ready_o, "beat accepted while a command executes")
  `OLT_ASSERT(a_fire_exec, in_fire |=> busy_q, "accepted beat did not execute")
  `OLT_ASSERT(a_cnt_quiet, !busy_q |=> $stable(cnt_q), "count changed outside execution")
  `OLT_ASSERT(a_out_from_exec, $rose(out_valid_q) |-> $past(busy_q),
              "result appeared without an executed command")

endmodule
`default_nettype wire
